>>> rtl/core/plrah_pkg.sv
package plrah_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned RING_W = 8;
    localparam int unsigned TONE_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [TIME_W-1:0] RING_RESTART_MS = 32'd7000;
    localparam logic [TIME_W-1:0] FLASH_WINDOW_MS = 32'd60000;
    localparam logic [RING_W-1:0] FLASH_MAX_RINGS = 8'd3;
    localparam logic [RING_W-1:0] RINGS_DEFAULT   = 8'd8;
    localparam logic [RING_W-1:0] RING_MAX        = 8'hFF;
    localparam logic [TONE_W-1:0] TONE_MAX        = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_RING     = 2'd0,
        CMD_TONE     = 2'd1,
        CMD_OFF_HOOK = 2'd2,
        CMD_HANG_UP  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RINGS_TO_ANSWER   = 3'd0,
        REG_FLASH_ENABLE      = 3'd1,
        REG_TONE_HANGUP_EN    = 3'd2,
        REG_TONE_GAP_MIN      = 3'd3,
        REG_TONE_GAP_MAX      = 3'd4,
        REG_TONE_PULSES       = 3'd5,
        REG_HOOK_ACTIVE_LEVEL = 3'd6,
        REG_UNUSED            = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [RING_W-1:0] rings_to_answer;
        logic              flash_enable;
        logic              tone_hangup_enable;
        logic [TIME_W-1:0] tone_gap_min;
        logic [TIME_W-1:0] tone_gap_max;
        logic [TONE_W-1:0] tone_pulses_to_hangup;
        logic              hook_active_level;
    } cfg_t;

    typedef struct packed {
        logic [RING_W-1:0] rings_counted;
        logic              tone_hung_up;
        logic              answered;
        logic              ring_seen;
        logic              is_off_hook;
        logic              hook_pin;
    } result_t;

endpackage

>>> rtl/core/plrah_cfg.sv
module plrah_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [plrah_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plrah_pkg::CFG_DATA_W-1:0]    cfg_data,
    output plrah_pkg::cfg_t                     cfg,
    output logic                                tone_clr
);
    import plrah_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;
    assign tone_clr  = wr && (reg_idx_t'(cfg_index) == REG_TONE_PULSES);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            unique case (reg_idx_t'(cfg_index))
                REG_RINGS_TO_ANSWER:   cfg_next.rings_to_answer = cfg_data[RING_W-1:0];
                REG_FLASH_ENABLE:      cfg_next.flash_enable = cfg_data[0];
                REG_TONE_HANGUP_EN:    cfg_next.tone_hangup_enable = cfg_data[0];
                REG_TONE_GAP_MIN:      cfg_next.tone_gap_min = cfg_data[TIME_W-1:0];
                REG_TONE_GAP_MAX:      cfg_next.tone_gap_max = cfg_data[TIME_W-1:0];
                REG_TONE_PULSES:       cfg_next.tone_pulses_to_hangup = cfg_data[TONE_W-1:0];
                REG_HOOK_ACTIVE_LEVEL: cfg_next.hook_active_level = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rings_to_answer       <= RINGS_DEFAULT;
            cfg_reg.flash_enable          <= 1'b0;
            cfg_reg.tone_hangup_enable    <= 1'b0;
            cfg_reg.tone_gap_min          <= '0;
            cfg_reg.tone_gap_max          <= '0;
            cfg_reg.tone_pulses_to_hangup <= '0;
            cfg_reg.hook_active_level     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/core/phone_line_ring_answer_hangup_core.sv
// channel   dir  handshake         payload
// s_        in   s_tvalid/tready   tdata: now_ms[31:0]; tuser: cmd[1:0]
// m_        out  m_tvalid/tready   tdata: hook_pin, is_off_hook, ring_seen, answered,
//                                         tone_hung_up, rings_counted[7:0], zero pad
// cfg_      in   cfg_valid/ready   cfg_index[2:0], cfg_data[31:0]
//
// one word per cycle sustained while m_tready stays high; a taken word passes through the
// input register, then the line state update into the result register, before it shows on m_
// aresetn is synchronous and active low, and restores the register defaults
// a stall on m_tready holds the result register and then the input register;
// s_tready drops only while both are full and m_tready is low
module phone_line_ring_answer_hangup_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [plrah_pkg::S_TDATA_W-1:0]     s_tdata,   // now_ms[31:0]
    input  logic [plrah_pkg::S_TUSER_W-1:0]     s_tuser,   // cmd[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hook_pin[0], is_off_hook[1], ring_seen[2], answered[3], tone_hung_up[4],
    // rings_counted[12:5], zero[15:13]
    output logic [plrah_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [plrah_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plrah_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import plrah_pkg::*;

    cfg_t cfg;
    logic tone_clr;

    plrah_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .tone_clr  (tone_clr)
    );

    // input register
    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              advance;
    logic              s_take;

    // line state
    logic              off_hook_reg, off_hook_next;
    logic [RING_W-1:0] ring_count_reg, ring_count_next;
    logic [TIME_W-1:0] last_ring_reg, last_ring_next;
    logic              tone_armed_reg, tone_armed_next;
    logic [TIME_W-1:0] last_tone_reg, last_tone_next;
    logic [TONE_W-1:0] tone_count_reg, tone_count_next;

    // result register
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_next;

    logic [TIME_W-1:0] ring_dt;
    logic [TIME_W-1:0] tone_dt;
    logic              gap_long;
    logic              quick;
    logic [RING_W-1:0] ring_base;
    logic [RING_W-1:0] ring_inc;
    logic [TONE_W-1:0] tone_inc;
    logic              tone_in_window;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_reg};

    assign ring_dt   = in_now_reg - last_ring_reg;
    assign tone_dt   = in_now_reg - last_tone_reg;
    assign gap_long  = (ring_count_reg != '0) && (ring_dt > RING_RESTART_MS);
    assign quick     = gap_long && cfg.flash_enable && (ring_count_reg <= FLASH_MAX_RINGS)
                       && (ring_dt <= FLASH_WINDOW_MS);
    assign ring_base = (gap_long && !quick) ? '0 : ring_count_reg;
    assign ring_inc  = (ring_base == RING_MAX) ? RING_MAX : ring_base + 1'b1;
    assign tone_inc  = (tone_count_reg == TONE_MAX) ? TONE_MAX : tone_count_reg + 1'b1;
    assign tone_in_window = (tone_dt >= cfg.tone_gap_min) && (tone_dt <= cfg.tone_gap_max);

    always_comb begin
        off_hook_next   = off_hook_reg;
        ring_count_next = ring_count_reg;
        last_ring_next  = last_ring_reg;
        tone_armed_next = tone_armed_reg;
        last_tone_next  = last_tone_reg;
        tone_count_next = tone_count_reg;
        out_next        = '0;
        if (advance) begin
            unique case (in_cmd_reg)
                CMD_RING: begin
                    last_ring_next     = in_now_reg;
                    ring_count_next    = ring_inc;
                    out_next.ring_seen = 1'b1;
                    if (!off_hook_reg) begin
                        if ((ring_inc >= cfg.rings_to_answer) || quick) begin
                            off_hook_next     = 1'b1;
                            out_next.answered = 1'b1;
                        end
                    end else begin
                        off_hook_next = 1'b0;
                    end
                end
                CMD_TONE: begin
                    if (cfg.tone_hangup_enable) begin
                        last_tone_next = in_now_reg;
                        if (!tone_armed_reg) begin
                            tone_armed_next = 1'b1;
                        end else if (tone_in_window) begin
                            if (tone_inc >= cfg.tone_pulses_to_hangup) begin
                                off_hook_next         = 1'b0;
                                out_next.tone_hung_up = 1'b1;
                                tone_count_next       = '0;
                                tone_armed_next       = 1'b0;
                                last_tone_next        = '0;
                            end else begin
                                tone_count_next = tone_inc;
                            end
                        end
                    end
                end
                CMD_OFF_HOOK: begin
                    off_hook_next = 1'b1;
                end
                CMD_HANG_UP: begin
                    off_hook_next   = 1'b0;
                    ring_count_next = '0;
                end
                default: ;
            endcase
        end
        if (tone_clr) begin
            tone_count_next = '0;
        end
        out_next.is_off_hook   = off_hook_next;
        out_next.hook_pin      = off_hook_next ? cfg.hook_active_level
                                               : !cfg.hook_active_level;
        out_next.rings_counted = ring_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            off_hook_reg   <= 1'b0;
            ring_count_reg <= '0;
            last_ring_reg  <= '0;
            tone_armed_reg <= 1'b0;
            last_tone_reg  <= '0;
            tone_count_reg <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            off_hook_reg   <= off_hook_next;
            ring_count_reg <= ring_count_next;
            last_ring_reg  <= last_ring_next;
            tone_armed_reg <= tone_armed_next;
            last_tone_reg  <= last_tone_next;
            tone_count_reg <= tone_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_cmd_reg <= cmd_t'(s_tuser);
            in_now_reg <= s_tdata[TIME_W-1:0];
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // answering always leaves the line off hook and comes from a ring
    a_answer_off_hook: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.answered |-> out_reg.is_off_hook && out_reg.ring_seen)
        else $error("answer without off hook or ring");

    // tone hangup leaves the line on hook and is never a ring word
    a_tone_on_hook: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.tone_hung_up |-> !out_reg.is_off_hook && !out_reg.ring_seen)
        else $error("tone hangup with line off hook");

    // an empty input register always takes a word
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

    // a word in the input register reaches the result register when it is free
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("word not moved to result register");

    // result word holds its flags while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_reg))
        else $error("result changed during stall");

endmodule

>>> dv/hook_line_checker.sv
module hook_line_checker
    import plrah_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // now_ms[31:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // cmd[1:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // hook_pin, is_off_hook, ring_seen, answered, tone_hung_up, rings_counted[7:0], zero pad
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int unsigned RES_W = $bits(result_t);

    cfg_t              line_cfg;
    logic              off_hook;
    logic [RING_W-1:0] ring_cnt;
    logic [TIME_W-1:0] last_ring;
    logic              tone_armed;
    logic [TIME_W-1:0] last_tone;
    logic [TONE_W-1:0] tone_cnt;
    result_t           expected_lines[$];

    task automatic clear_line();
        line_cfg                       = '0;
        line_cfg.rings_to_answer       = RINGS_DEFAULT;
        off_hook                       = 1'b0;
        ring_cnt                       = '0;
        last_ring                      = '0;
        tone_armed                     = 1'b0;
        last_tone                      = '0;
        tone_cnt                       = '0;
    endtask

    task automatic apply_setting(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_RINGS_TO_ANSWER:   line_cfg.rings_to_answer = d[RING_W-1:0];
            REG_FLASH_ENABLE:      line_cfg.flash_enable = d[0];
            REG_TONE_HANGUP_EN:    line_cfg.tone_hangup_enable = d[0];
            REG_TONE_GAP_MIN:      line_cfg.tone_gap_min = d[TIME_W-1:0];
            REG_TONE_GAP_MAX:      line_cfg.tone_gap_max = d[TIME_W-1:0];
            REG_TONE_PULSES: begin
                line_cfg.tone_pulses_to_hangup = d[TONE_W-1:0];
                tone_cnt = '0;
            end
            REG_HOOK_ACTIVE_LEVEL: line_cfg.hook_active_level = d[0];
            default: ;
        endcase
    endtask

    function automatic result_t line_after_event(input cmd_t c, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] dt;
        logic              quick;
        result_t           r;
        r     = '0;
        quick = 1'b0;
        case (c)
            CMD_RING: begin
                dt        = now - last_ring;
                last_ring = now;
                if (ring_cnt != 0 && dt > RING_RESTART_MS) begin
                    if (line_cfg.flash_enable && ring_cnt <= FLASH_MAX_RINGS &&
                        dt <= FLASH_WINDOW_MS) begin
                        quick = 1'b1;
                    end else begin
                        ring_cnt = '0;
                    end
                end
                if (ring_cnt != RING_MAX) begin
                    ring_cnt = ring_cnt + 1'b1;
                end
                r.ring_seen = 1'b1;
                if (!off_hook) begin
                    if (ring_cnt >= line_cfg.rings_to_answer || quick) begin
                        off_hook   = 1'b1;
                        r.answered = 1'b1;
                    end
                end else begin
                    off_hook = 1'b0;
                end
            end
            CMD_TONE: begin
                if (line_cfg.tone_hangup_enable) begin
                    if (!tone_armed) begin
                        tone_armed = 1'b1;
                        last_tone  = now;
                    end else begin
                        dt        = now - last_tone;
                        last_tone = now;
                        if (dt >= line_cfg.tone_gap_min && dt <= line_cfg.tone_gap_max) begin
                            if (tone_cnt != TONE_MAX) begin
                                tone_cnt = tone_cnt + 1'b1;
                            end
                            if (tone_cnt >= line_cfg.tone_pulses_to_hangup) begin
                                off_hook       = 1'b0;
                                r.tone_hung_up = 1'b1;
                                tone_cnt       = '0;
                                tone_armed     = 1'b0;
                                last_tone      = '0;
                            end
                        end
                    end
                end
            end
            CMD_OFF_HOOK: off_hook = 1'b1;
            default: begin
                off_hook = 1'b0;
                ring_cnt = '0;
            end
        endcase
        r.hook_pin      = off_hook ? line_cfg.hook_active_level : ~line_cfg.hook_active_level;
        r.is_off_hook   = off_hook;
        r.rings_counted = ring_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40) begin
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        end
        fail_count++;
    endtask

    task automatic compare_line(input logic [M_TDATA_W-1:0] word, input result_t want);
        result_t got;
        got = word[RES_W-1:0];
        if (got.hook_pin !== want.hook_pin)
            report_mismatch("hook_pin", got.hook_pin, want.hook_pin);
        if (got.is_off_hook !== want.is_off_hook)
            report_mismatch("is_off_hook", got.is_off_hook, want.is_off_hook);
        if (got.ring_seen !== want.ring_seen)
            report_mismatch("ring_seen", got.ring_seen, want.ring_seen);
        if (got.answered !== want.answered)
            report_mismatch("answered", got.answered, want.answered);
        if (got.tone_hung_up !== want.tone_hung_up)
            report_mismatch("tone_hung_up", got.tone_hung_up, want.tone_hung_up);
        if (got.rings_counted !== want.rings_counted)
            report_mismatch("rings_counted", got.rings_counted, want.rings_counted);
        if (word[M_TDATA_W-1:RES_W] !== '0)
            report_mismatch("pad bits", word[M_TDATA_W-1:RES_W], 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_line();
            expected_lines.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_lines.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata, 0);
                end else begin
                    compare_line(m_tdata, expected_lines.pop_front());
                end
            end
            if (cfg_valid && cfg_ready) begin
                apply_setting(reg_idx_t'(cfg_index), cfg_data);
            end
            if (s_tvalid && s_tready) begin
                expected_lines.push_back(line_after_event(cmd_t'(s_tuser), s_tdata));
            end
            pending = expected_lines.size();
        end
    end

endmodule

>>> dv/phone_line_ring_answer_hangup_core_test.sv
module phone_line_ring_answer_hangup_core_test;
    import plrah_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // now_ms[31:0]
    logic [S_TUSER_W-1:0]  s_tuser;    // cmd[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    // hook_pin, is_off_hook, ring_seen, answered, tone_hung_up, rings_counted[7:0], zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    int                    squeeze_ask;
    bit                    calm_tx;
    logic [TIME_W-1:0]     ring_t;
    logic [TIME_W-1:0]     tone_t;
    logic [TIME_W-1:0]     tone_lo;
    logic [TIME_W-1:0]     tone_hi;

    phone_line_ring_answer_hangup_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hook_line_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #12000000;
        $display("FAILED: results differ");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pad_noise(input logic [CFG_DATA_W-1:0] v,
                                                        input int w);
        if ($urandom_range(0, 1) == 0) return v;
        return v | ($urandom << w);
    endfunction

    function automatic logic [TIME_W-1:0] ring_gap();
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, RING_RESTART_MS);
            6:  return RING_RESTART_MS;
            7:  return RING_RESTART_MS + 1;
            8:  return $urandom_range(RING_RESTART_MS + 1, FLASH_WINDOW_MS);
            9:  return FLASH_WINDOW_MS;
            10: return FLASH_WINDOW_MS + 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] tone_gap();
        case ($urandom_range(0, 7))
            0: return tone_lo;
            1: return tone_hi;
            2: return tone_lo - 1;
            3: return tone_hi + 1;
            7: return $urandom;
            default: return (tone_hi >= tone_lo) ? $urandom_range(tone_lo, tone_hi) : $urandom;
        endcase
    endfunction

    task automatic send_event(input cmd_t c, input logic [TIME_W-1:0] now);
        int gap;
        gap = calm_tx ? 0 : pick_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= now;
        s_tuser  <= c;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // lower valid, then wait until every word sent has come back
    task automatic settle_line();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_tone_window(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
        write_reg(REG_TONE_GAP_MIN, lo);
        write_reg(REG_TONE_GAP_MAX, hi);
        tone_lo = lo;
        tone_hi = hi;
    endtask

    task automatic pick_settings();
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic [RING_W-1:0] rings;
        logic [TONE_W-1:0] pulses;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
                0: rings = 8'd1;
                1: rings = RING_MAX;
                2: rings = 8'd0;
                default: rings = $urandom_range(1, 6);
            endcase
            write_reg(REG_RINGS_TO_ANSWER, pad_noise(rings, RING_W));
        end
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_FLASH_ENABLE, pad_noise($urandom_range(0, 1), 1));
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_TONE_HANGUP_EN, pad_noise($urandom_range(0, 4) != 0, 1));
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
                0: begin
                    lo = '0;
                    hi = '1;
                end
                1: begin
                    lo = $urandom_range(0, 300);
                    hi = lo;
                end
                2: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                3: begin
                    lo = $urandom_range(200, 500);
                    hi = $urandom_range(0, 199);
                end
                default: begin
                    lo = $urandom_range(0, 400);
                    hi = lo + $urandom_range(0, 400);
                end
            endcase
            write_tone_window(lo, hi);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
                0: pulses = '0;
                1: pulses = TONE_MAX;
                default: pulses = $urandom_range(1, 6);
            endcase
            write_reg(REG_TONE_PULSES, pad_noise(pulses, TONE_W));
        end
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_HOOK_ACTIVE_LEVEL, pad_noise($urandom_range(0, 1), 1));
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_UNUSED, $urandom);
    endtask

    task automatic run_line_traffic(input int n_items);
        int i;
        int j;
        int kind;
        int burst;
        logic [TIME_W-1:0] now;
        i       = 0;
        ring_t  = $urandom;
        tone_t  = $urandom;
        calm_tx = ($urandom_range(0, 3) == 0);
        while (i < n_items) begin
            kind  = $urandom_range(0, 99);
            burst = $urandom_range(1, 12);
            for (j = 0; j < burst && i < n_items; j++) begin
                if (kind < 50) begin
                    now    = ring_t + ring_gap();
                    ring_t = now;
                    send_event(CMD_RING, now);
                end else if (kind < 85) begin
                    now    = tone_t + tone_gap();
                    tone_t = now;
                    send_event(CMD_TONE, now);
                end else if (kind < 91) begin
                    send_event(CMD_OFF_HOOK, $urandom);
                end else if (kind < 97) begin
                    send_event(CMD_HANG_UP, $urandom);
                end else begin
                    send_event(cmd_t'($urandom_range(0, 3)), $urandom);
                end
                i++;
            end
        end
    endtask

    initial begin : rx_side
        int hold;
        int squeeze_done;
        bit rx_calm;
        squeeze_done = 0;
        rx_calm      = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (squeeze_ask != squeeze_done) begin
                squeeze_done++;
                hold = 64;
            end else if (rx_calm) begin
                hold = 0;
            end else begin
                hold = pick_idle();
            end
            if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : tx_side
        int i;
        int phase;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_RING;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_RINGS_TO_ANSWER;
        cfg_data    <= '0;
        squeeze_ask <= 0;
        calm_tx = 1'b0;
        tone_lo = '0;
        tone_hi = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults after reset: restart on long pause, release while off hook
        send_event(CMD_RING, 32'd100);
        send_event(CMD_RING, 32'd7100);
        send_event(CMD_RING, 32'd14101);
        send_event(CMD_TONE, 32'd500);
        send_event(CMD_OFF_HOOK, 32'd0);
        send_event(CMD_RING, 32'd15000);
        send_event(CMD_HANG_UP, 32'hFFFF_FFFF);
        settle_line();

        // threshold zero, inverted hook level, tone window with wrap
        write_reg(REG_RINGS_TO_ANSWER, 32'd0);
        write_reg(REG_FLASH_ENABLE, 32'd1);
        write_reg(REG_TONE_HANGUP_EN, 32'd1);
        write_tone_window(32'd100, 32'd200);
        write_reg(REG_TONE_PULSES, 32'd0);
        write_reg(REG_HOOK_ACTIVE_LEVEL, 32'd1);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_event(CMD_RING, 32'hFFFF_FFF0);
        send_event(CMD_RING, 32'h0000_1000);
        send_event(CMD_OFF_HOOK, 32'd5);
        send_event(CMD_TONE, 32'hFFFF_FFC0);
        send_event(CMD_TONE, 32'h0000_0056);
        send_event(CMD_TONE, 32'd1000);
        send_event(CMD_TONE, 32'd1099);
        send_event(CMD_TONE, 32'd1300);
        send_event(CMD_TONE, 32'd1500);
        settle_line();

        // quick answer on flash, full tone window
        write_reg(REG_RINGS_TO_ANSWER, {24'd0, RING_MAX});
        write_reg(REG_TONE_PULSES, 32'd3);
        write_tone_window('0, '1);
        write_reg(REG_HOOK_ACTIVE_LEVEL, 32'd0);
        send_event(CMD_HANG_UP, 32'd0);
        send_event(CMD_RING, 32'd0);
        send_event(CMD_RING, 32'd5000);
        send_event(CMD_RING, 32'd10000);
        send_event(CMD_RING, 32'd70000);
        send_event(CMD_RING, 32'd75000);
        send_event(CMD_RING, 32'd135001);
        send_event(CMD_RING, 32'd195001);
        send_event(CMD_TONE, 32'd7);
        settle_line();

        // long ring run up to saturation, with the receiver held off once during the run
        write_reg(REG_RINGS_TO_ANSWER, {24'd0, RING_MAX});
        write_reg(REG_FLASH_ENABLE, 32'd0);
        squeeze_ask <= squeeze_ask + 1;
        calm_tx = 1'b1;
        ring_t  = $urandom;
        for (i = 0; i < 300; i++) begin
            ring_t = ring_t + $urandom_range(1, RING_RESTART_MS);
            send_event(CMD_RING, ring_t);
        end
        settle_line();

        for (phase = 0; phase < 11; phase++) begin
            pick_settings();
            run_line_traffic(150);
            settle_line();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/plrah_pkg.sv
rtl/core/plrah_cfg.sv
rtl/core/phone_line_ring_answer_hangup_core.sv
dv/hook_line_checker.sv
dv/phone_line_ring_answer_hangup_core_test.sv
